@@ design/utcb_pkg.sv @@
// shared constants, descriptor kind codes and controller/datapath link types
package utcb_pkg;

  // descriptor pool geometry
  localparam int POOL_SLOTS = 32;
  localparam int SLOT_BYTES = 32;
  localparam int MAX_CHAIN  = 32;

  // packet ids
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_OUT   = 8'he1;
  localparam logic [7:0] PID_SETUP = 8'h2d;

  // status word fields
  localparam logic [31:0] STATUS_BASE = (32'd3 << 27) | (32'd1 << 23);
  localparam logic [31:0] STATUS_LS   = 32'd1 << 26;

  // link word marks
  localparam logic [3:0]  LINK_DEPTH = 4'b0100;
  localparam logic [31:0] LINK_TERM  = 32'd1;

  // kind of descriptor loaded into the output register
  localparam logic [2:0] KIND_SETUP  = 3'd0;
  localparam logic [2:0] KIND_DATA   = 3'd1;
  localparam logic [2:0] KIND_STATUS = 3'd2;
  localparam logic [2:0] KIND_INTR   = 3'd3;
  localparam logic [2:0] KIND_ERR    = 3'd4;

  typedef struct packed {
    logic       load;
    logic       count_step;
    logic       start_emit;
    logic       emit;
    logic [2:0] kind;
  } utcb_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic count_full;
    logic is_intr;
    logic fit;
    logic out_free;
  } utcb_stat_t;

endpackage

@@ design/utcb_dp.sv @@
// datapath: request registers, length walker, slot counter and output register
module utcb_dp import utcb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  utcb_cmd_t   cmd,
  output utcb_stat_t  stat,
  input  logic [6:0]  max_packet,
  input  logic [31:0] td_pool_base,
  input  logic        mode,
  input  logic        low_speed,
  input  logic [6:0]  dev_addr,
  input  logic [3:0]  endpoint,
  input  logic        initial_toggle,
  input  logic        dir_in,
  input  logic [11:0] length,
  input  logic [31:0] setup_addr,
  input  logic [31:0] data_addr,
  input  logic [4:0]  first_slot,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [4:0]  td_slot,
  output logic [31:0] link_word,
  output logic [31:0] status_word,
  output logic [31:0] token_word,
  output logic [31:0] buffer_word,
  output logic        pool_error,
  output logic        last
);

  logic        r_mode;
  logic        r_ls;
  logic [6:0]  r_dev;
  logic [3:0]  r_endp;
  logic        r_tog0;
  logic        r_dir;
  logic [11:0] r_len;
  logic [31:0] r_setup;
  logic [31:0] r_data;
  logic [4:0]  r_first;

  logic [11:0] rem;
  logic [11:0] off;
  logic [5:0]  n;
  logic [5:0]  slot;
  logic        tog;

  logic [6:0]  mp;
  logic [11:0] sz;
  logic [6:0]  cnt;
  logic [31:0] next_addr;

  // per-kind field selection
  logic        f_tog;
  logic [3:0]  f_endp;
  logic [7:0]  f_pid;
  logic [11:0] f_len;
  logic [11:0] f_len_m1;
  logic [31:0] f_buf;
  logic        f_last;
  logic        f_err;

  assign mp = (max_packet == 7'd0) ? 7'd1 : max_packet;
  assign sz = (rem > {5'd0, mp}) ? {5'd0, mp} : rem;
  assign cnt = r_mode ? 7'd1 : ({1'b0, n} + 7'd2);
  assign next_addr = td_pool_base + ({26'd0, slot} + 32'd1) * 32'(SLOT_BYTES);

  assign stat.rem_zero   = (rem == 12'd0);
  assign stat.count_full = (n == 6'(MAX_CHAIN - 1));
  assign stat.is_intr    = r_mode;
  assign stat.fit        = (cnt <= 7'(MAX_CHAIN)) &&
                           (({3'd0, r_first} + {1'b0, cnt}) <= 8'(POOL_SLOTS));
  assign stat.out_free   = !out_valid || out_ready;

  always_comb begin
    f_tog  = 1'b0;
    f_endp = 4'd0;
    f_pid  = PID_SETUP;
    f_len  = 12'd8;
    f_buf  = r_setup;
    f_last = 1'b0;
    f_err  = 1'b0;
    case (cmd.kind)
      KIND_SETUP: begin
      end
      KIND_DATA: begin
        f_tog = ~tog;
        f_pid = r_dir ? PID_IN : PID_OUT;
        f_len = sz;
        f_buf = r_data + {20'd0, off};
      end
      KIND_STATUS: begin
        f_tog  = 1'b1;
        f_pid  = r_dir ? PID_OUT : PID_IN;
        f_len  = 12'd0;
        f_buf  = 32'd0;
        f_last = 1'b1;
      end
      KIND_INTR: begin
        f_tog  = r_tog0;
        f_endp = r_endp;
        f_pid  = PID_IN;
        f_len  = r_len;
        f_buf  = r_data;
        f_last = 1'b1;
      end
      default: begin
        f_last = 1'b1;
        f_err  = 1'b1;
      end
    endcase
  end

  assign f_len_m1 = f_len - 12'd1;

  // request capture, length walk, and slot / offset / toggle advance per emitted descriptor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode  <= mode;
      r_ls    <= low_speed;
      r_dev   <= dev_addr;
      r_endp  <= endpoint;
      r_tog0  <= initial_toggle;
      r_dir   <= dir_in;
      r_len   <= length;
      r_setup <= setup_addr;
      r_data  <= data_addr;
      r_first <= first_slot;
      rem     <= length;
      n       <= 6'd0;
    end else if (cmd.count_step) begin
      rem <= rem - sz;
      n   <= n + 6'd1;
    end else if (cmd.start_emit) begin
      rem  <= r_len;
      off  <= 12'd0;
      slot <= {1'b0, r_first};
      tog  <= 1'b0;
    end else if (cmd.emit) begin
      slot <= slot + 6'd1;
      if (cmd.kind == KIND_DATA) begin
        rem <= rem - sz;
        off <= off + sz;
        tog <= ~tog;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      td_slot    <= slot[4:0];
      pool_error <= f_err;
      last       <= f_last;
      if (f_err) begin
        link_word   <= 32'd0;
        status_word <= 32'd0;
        token_word  <= 32'd0;
        buffer_word <= 32'd0;
      end else begin
        link_word   <= f_last ? LINK_TERM : {next_addr[31:4], LINK_DEPTH};
        status_word <= STATUS_BASE | (r_ls ? STATUS_LS : 32'd0);
        token_word  <= {f_len_m1[10:0], 1'b0, f_tog, f_endp, r_dev[6:0], f_pid};
        buffer_word <= f_buf;
      end
    end
  end

endmodule

@@ design/utcb_ctrl.sv @@
// controller: sequences count, fit check and descriptor emission
module utcb_ctrl import utcb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  utcb_stat_t stat,
  output utcb_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DATA  = 3'd3;
  localparam logic [2:0] S_INTR  = 3'd4;
  localparam logic [2:0] S_ERR   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.count_step = 1'b0;
    cmd.start_emit = 1'b0;
    cmd.emit       = 1'b0;
    cmd.kind       = KIND_SETUP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        if (stat.is_intr || stat.rem_zero || stat.count_full) begin
          cmd.start_emit = 1'b1;
          if (!stat.fit) begin
            state_next = S_ERR;
          end else if (stat.is_intr) begin
            state_next = S_INTR;
          end else begin
            state_next = S_SETUP;
          end
        end else begin
          cmd.count_step = 1'b1;
        end
      end
      S_SETUP: begin
        cmd.kind = KIND_SETUP;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_DATA;
        end
      end
      S_DATA: begin
        cmd.kind = stat.rem_zero ? KIND_STATUS : KIND_DATA;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.rem_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      S_INTR: begin
        cmd.kind = KIND_INTR;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.kind = KIND_ERR;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/usb_td_chain_builder_unit.sv @@
// top level: apb register file, controller and datapath of the td chain builder
// sequence: request beat, then a length walk that counts the data tds (control requests),
// then the descriptor beats, one beat per cycle while out_ready is held; a new request is
// taken only once the last beat of the previous one has been emitted
// reset: synchronous, clears the controller and output valid; max_packet 8, pool base 0
module usb_td_chain_builder_unit import utcb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic        low_speed,
  input  logic [6:0]  dev_addr,
  input  logic [3:0]  endpoint,
  input  logic        initial_toggle,
  input  logic        dir_in,
  input  logic [11:0] length,
  input  logic [31:0] setup_addr,
  input  logic [31:0] data_addr,
  input  logic [4:0]  first_slot,
  // descriptor channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  td_slot,
  output logic [31:0] link_word,
  output logic [31:0] status_word,
  output logic [31:0] token_word,
  output logic [31:0] buffer_word,
  output logic        pool_error,
  output logic        last
);

  // configuration registers, paddr[2] picks the register
  logic [6:0]  max_packet;
  logic [31:0] td_pool_base;

  utcb_cmd_t  cmd;
  utcb_stat_t stat;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? td_pool_base : {25'd0, max_packet};

  // write lands on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet   <= 7'd8;
      td_pool_base <= 32'd0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        td_pool_base <= pwdata;
      end else begin
        max_packet <= pwdata[6:0];
      end
    end
  end

  // state machine: idle, length walk, then setup / data / status, the single interrupt td or an error beat
  utcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // request registers, chunk walker, descriptor assembly and output beat register
  utcb_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .max_packet     (max_packet),
    .td_pool_base   (td_pool_base),
    .mode           (mode),
    .low_speed      (low_speed),
    .dev_addr       (dev_addr),
    .endpoint       (endpoint),
    .initial_toggle (initial_toggle),
    .dir_in         (dir_in),
    .length         (length),
    .setup_addr     (setup_addr),
    .data_addr      (data_addr),
    .first_slot     (first_slot),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .td_slot        (td_slot),
    .link_word      (link_word),
    .status_word    (status_word),
    .token_word     (token_word),
    .buffer_word    (buffer_word),
    .pool_error     (pool_error),
    .last           (last)
  );

  // in_ready drops in the cycle after a request beat is taken, while the walk runs
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

  // an error beat ends the request and carries no descriptor
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && pool_error) |-> (last && link_word == 32'd0 && token_word == 32'd0))
    else $error("error beat malformed");

  // every descriptor but the last links depth first to the next one
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (link_word[2] && !link_word[0] && !pool_error))
    else $error("inner descriptor link malformed");

  // descriptors are only loaded when the output register can take them
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("descriptor beat overwritten");

endmodule

@@ tb/usb_td_chain_builder_unit_tb.sv @@
// self-checking testbench for the uhci td chain builder: random and directed requests
`timescale 1ns / 100ps

module usb_td_chain_builder_unit_tb import utcb_pkg::*; ();

  // request modes
  localparam logic MODE_CONTROL = 1'b0;
  localparam logic MODE_INTR    = 1'b1;

  // register byte addresses
  localparam logic [2:0] REG_MAX_PACKET = 3'd0;
  localparam logic [2:0] REG_POOL_BASE  = 3'd4;

  // generous bound, covers long length walks on oversized error requests
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic        mode;
    logic        low_speed;
    logic [6:0]  dev_addr;
    logic [3:0]  endpoint;
    logic        toggle;
    logic        dir_in;
    logic [11:0] length;
    logic [31:0] setup_addr;
    logic [31:0] data_addr;
    logic [4:0]  first_slot;
  } td_request_t;

  typedef struct {
    logic [4:0]  slot;
    logic [31:0] link;
    logic [31:0] status;
    logic [31:0] token;
    logic [31:0] buf_addr;
    logic        pool_error;
    logic        is_last;
  } td_desc_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  // configuration port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // request channel
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic        low_speed = 1'b0;
  logic [6:0]  dev_addr = '0;
  logic [3:0]  endpoint = '0;
  logic        initial_toggle = 1'b0;
  logic        dir_in = 1'b0;
  logic [11:0] length = '0;
  logic [31:0] setup_addr = '0;
  logic [31:0] data_addr = '0;
  logic [4:0]  first_slot = '0;

  // descriptor channel
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  td_slot;
  logic [31:0] link_word;
  logic [31:0] status_word;
  logic [31:0] token_word;
  logic [31:0] buffer_word;
  logic        pool_error;
  logic        last;

  // shadow copy of the register file, updated on each apb write
  logic [6:0]  cfg_max_packet = 7'd8;
  logic [31:0] cfg_pool_base = '0;

  td_request_t req_q[$];     // requests waiting to be offered
  td_desc_t    desc_q[$];    // descriptors predicted but not yet seen
  td_request_t cur_req;      // request currently on the pins
  td_desc_t    exp_desc;
  bit          offer;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  usb_td_chain_builder_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .low_speed      (low_speed),
    .dev_addr       (dev_addr),
    .endpoint       (endpoint),
    .initial_toggle (initial_toggle),
    .dir_in         (dir_in),
    .length         (length),
    .setup_addr     (setup_addr),
    .data_addr      (data_addr),
    .first_slot     (first_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .td_slot        (td_slot),
    .link_word      (link_word),
    .status_word    (status_word),
    .token_word     (token_word),
    .buffer_word    (buffer_word),
    .pool_error     (pool_error),
    .last           (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // one descriptor as the hardware should lay it out
  function automatic td_desc_t make_desc(input int unsigned slot, input bit is_last,
                                         input logic ls, input logic [6:0] dev,
                                         input logic [3:0] endp, input logic tog,
                                         input logic [7:0] pid, input logic [31:0] len,
                                         input logic [31:0] buf_addr);
    td_desc_t    d;
    logic [31:0] next_addr;
    logic [31:0] maxlen;
    next_addr = cfg_pool_base + (slot + 1) * SLOT_BYTES;
    // maxlen field is len-1, so a zero length wraps to the null-packet code
    maxlen = len - 1;
    d.slot = slot[4:0];
    // link points depth first at the next slot, low nibble of the address dropped
    d.link = is_last ? LINK_TERM : {next_addr[31:4], LINK_DEPTH};
    d.status = STATUS_BASE | (ls ? STATUS_LS : 32'd0);
    d.token = {maxlen[10:0], 1'b0, tog, endp, dev, pid};
    d.buf_addr = buf_addr;
    d.pool_error = 1'b0;
    d.is_last = is_last;
    return d;
  endfunction

  // expected descriptor chain of one accepted request
  function automatic void build_chain(input td_request_t r);
    int unsigned mp, ndata, count, off, sz, k;
    logic        tog;
    logic [7:0]  data_pid, status_pid;
    td_desc_t    d;
    // a zero max_packet behaves as one byte
    mp = (cfg_max_packet == 0) ? 1 : cfg_max_packet;
    if (r.mode == MODE_CONTROL) begin
      ndata = (r.length + mp - 1) / mp;
      count = ndata + 2;
    end else begin
      ndata = 0;
      count = 1;
    end
    // chain too long or runs past the end of the pool: single error beat
    if (count > MAX_CHAIN || r.first_slot + count > POOL_SLOTS) begin
      d.slot = r.first_slot;
      d.link = '0;
      d.status = '0;
      d.token = '0;
      d.buf_addr = '0;
      d.pool_error = 1'b1;
      d.is_last = 1'b1;
      desc_q.push_back(d);
      return;
    end
    if (r.mode == MODE_INTR) begin
      desc_q.push_back(make_desc(r.first_slot, 1'b1, r.low_speed, r.dev_addr, r.endpoint,
                                 r.toggle, PID_IN, r.length, r.data_addr));
      return;
    end
    data_pid = r.dir_in ? PID_IN : PID_OUT;
    status_pid = r.dir_in ? PID_OUT : PID_IN;
    // setup stage: 8 bytes, endpoint 0, toggle 0
    desc_q.push_back(make_desc(r.first_slot, 1'b0, r.low_speed, r.dev_addr, 4'd0, 1'b0,
                               PID_SETUP, 32'd8, r.setup_addr));
    // data stage: max_packet chunks, toggle starts at 1 and alternates
    off = 0;
    tog = 1'b0;
    for (k = 1; k <= ndata; k++) begin
      sz = r.length - off;
      if (sz > mp) sz = mp;
      tog = ~tog;
      desc_q.push_back(make_desc(r.first_slot + k, 1'b0, r.low_speed, r.dev_addr, 4'd0, tog,
                                 data_pid, sz, r.data_addr + off));
      off += sz;
    end
    // status stage: opposite direction, toggle 1, zero length, no buffer
    desc_q.push_back(make_desc(r.first_slot + ndata + 1, 1'b1, r.low_speed, r.dev_addr, 4'd0,
                               1'b1, status_pid, 32'd0, 32'd0));
  endfunction

  function automatic td_request_t req_of(input logic m, input logic ls, input logic [6:0] dev,
                                         input logic [3:0] endp, input logic tog,
                                         input logic dir, input logic [11:0] len,
                                         input logic [31:0] setup, input logic [31:0] data,
                                         input logic [4:0] first);
    td_request_t r;
    r.mode = m;
    r.low_speed = ls;
    r.dev_addr = dev;
    r.endpoint = endp;
    r.toggle = tog;
    r.dir_in = dir;
    r.length = len;
    r.setup_addr = setup;
    r.data_addr = data;
    r.first_slot = first;
    return r;
  endfunction

  // mostly chains that fit the pool, some interrupt requests, some oversized noise
  function automatic td_request_t random_request();
    td_request_t r;
    int unsigned mp, maxn, nd, pick;
    mp = (cfg_max_packet == 0) ? 1 : cfg_max_packet;
    r = req_of(1'($urandom), 1'($urandom), 7'($urandom), 4'($urandom), 1'($urandom),
               1'($urandom), 12'($urandom), $urandom, $urandom, 5'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // interrupt: always fits, any 12-bit length
      r.mode = MODE_INTR;
    end else if (pick < 85) begin
      // control sized to land inside the pool
      r.mode = MODE_CONTROL;
      r.first_slot = 5'($urandom_range(0, POOL_SLOTS - 2));
      maxn = POOL_SLOTS - 2 - r.first_slot;
      nd = $urandom_range(0, maxn);
      r.length = (nd == 0) ? 12'd0 : 12'((nd - 1) * mp + $urandom_range(1, mp));
    end else begin
      // control with unconstrained length and slot, often does not fit
      r.mode = MODE_CONTROL;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endfunction

  // apb write with a setup then an access phase, register lands on the access edge
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_MAX_PACKET) cfg_max_packet = data[6:0];
    else cfg_pool_base = data;
  endtask

  // block until every request is taken and every descriptor has come back
  task automatic wait_drained();
    do @(negedge clk); while (req_q.size() != 0 || in_valid || desc_q.size() != 0);
  endtask

  task automatic run_phase(input logic [6:0] mp_val, input logic [31:0] base_val,
                           input int sender_idle, input int recv_stall, input int n_items);
    apb_write(REG_MAX_PACKET, {25'd0, mp_val});
    apb_write(REG_POOL_BASE, base_val);
    send_idle_pct = sender_idle;
    recv_stall_pct = recv_stall;
    repeat (n_items) req_q.push_back(random_request());
    wait_drained();
  endtask

  // request driver: predicts on each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        build_chain(cur_req);
        offer = 1'b1;
      end else begin
        offer = !in_valid;
      end
      // valid held with a stable payload until the beat is taken
      if (offer) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          in_valid <= 1'b1;
          mode <= cur_req.mode;
          low_speed <= cur_req.low_speed;
          dev_addr <= cur_req.dev_addr;
          endpoint <= cur_req.endpoint;
          initial_toggle <= cur_req.toggle;
          dir_in <= cur_req.dir_in;
          length <= cur_req.length;
          setup_addr <= cur_req.setup_addr;
          data_addr <= cur_req.data_addr;
          first_slot <= cur_req.first_slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // descriptor monitor: random backpressure and in-order compare
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (desc_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected descriptor beat, expected none, actual slot %0d",
                   $time, td_slot);
        end else begin
          exp_desc = desc_q.pop_front();
          check_field("td_slot", exp_desc.slot, td_slot);
          check_field("link_word", exp_desc.link, link_word);
          check_field("status_word", exp_desc.status, status_word);
          check_field("token_word", exp_desc.token, token_word);
          check_field("buffer_word", exp_desc.buf_addr, buffer_word);
          check_field("pool_error", exp_desc.pool_error, pool_error);
          check_field("last", exp_desc.is_last, last);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset defaults: max_packet 8, pool base 0
    // zero-length control, both directions, ignored endpoint and toggle
    req_q.push_back(req_of(MODE_CONTROL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    req_q.push_back(req_of(MODE_CONTROL, 1, 127, 15, 1, 1, 0, 32'hffff_ffff,
                           32'hffff_ffff, 30));
    // one byte, one full packet, one packet plus a byte
    req_q.push_back(req_of(MODE_CONTROL, 0, 5, 0, 0, 1, 1, 32'h1000, 32'h2000, 3));
    req_q.push_back(req_of(MODE_CONTROL, 0, 5, 0, 0, 0, 8, 32'h1000, 32'h2000, 7));
    req_q.push_back(req_of(MODE_CONTROL, 1, 64, 0, 0, 1, 9, 32'h40, 32'h80, 11));
    // chain of exactly 32 descriptors, then one too many
    req_q.push_back(req_of(MODE_CONTROL, 0, 1, 0, 0, 1, 240, 32'h100, 32'h200, 0));
    req_q.push_back(req_of(MODE_CONTROL, 0, 1, 0, 0, 0, 241, 32'h100, 32'h200, 0));
    // fits the pool tail exactly, then runs past it
    req_q.push_back(req_of(MODE_CONTROL, 0, 9, 0, 0, 0, 8, 32'h300, 32'h400, 29));
    req_q.push_back(req_of(MODE_CONTROL, 0, 9, 0, 0, 0, 9, 32'h300, 32'h400, 29));
    req_q.push_back(req_of(MODE_CONTROL, 1, 9, 0, 0, 1, 0, 32'h300, 32'h400, 31));
    // very long control transfers never fit
    req_q.push_back(req_of(MODE_CONTROL, 0, 33, 3, 1, 1, 2048, 32'h500, 32'h600, 0));
    req_q.push_back(req_of(MODE_CONTROL, 0, 33, 3, 1, 0, 4095, 32'h500, 32'h600, 5));
    // data buffer address wraps past 32 bits
    req_q.push_back(req_of(MODE_CONTROL, 0, 77, 0, 0, 1, 20, 32'h0, 32'hffff_fff8, 12));
    // interrupt: null packet, one byte, long lengths that wrap the maxlen field
    req_q.push_back(req_of(MODE_INTR, 1, 127, 15, 1, 0, 0, 0, 32'hdead_beef, 31));
    req_q.push_back(req_of(MODE_INTR, 0, 0, 0, 0, 0, 1, 0, 32'h10, 0));
    req_q.push_back(req_of(MODE_INTR, 0, 42, 7, 1, 0, 2048, 0, 32'h20, 16));
    req_q.push_back(req_of(MODE_INTR, 1, 42, 8, 0, 1, 4095, 0, 32'h30, 17));
    req_q.push_back(req_of(MODE_INTR, 0, 42, 1, 1, 0, 2049, 0, 32'h40, 18));
    // interrupt ignores direction and setup address
    req_q.push_back(req_of(MODE_INTR, 0, 85, 10, 0, 1, 64, 32'hffff_ffff, 32'h50, 0));
    req_q.push_back(req_of(MODE_INTR, 1, 85, 10, 1, 0, 1023, 32'h1234, 32'h60, 25));
    wait_drained();

    // random phases, one config and idle pattern each; the drain between them
    // also makes the sender sit out until every descriptor is back
    run_phase(7'd64, 32'hffff_ffe0, 0, 0, 50);       // 64-byte packet, base wraps
    run_phase(7'd0, 32'h1234_5678, 72, 0, 50);       // zero max_packet, unaligned base
    run_phase(7'd127, 32'h8000_0000, 0, 72, 50);     // above 64 used as written
    run_phase(7'd1, $urandom & 32'hffff_ffe0, 38, 38, 50);
    run_phase(7'($urandom_range(1, 64)), $urandom, 0, 0, 50);

    // settle, then catch any late extra beats
    repeat (40) @(posedge clk);
    if (error_count == 0 && desc_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
